// File: hdl/x86m_pkg.sv
// Shared types, opcode group codes and register reset values for the MOV subset executor.
// Used by every module of the block but x86m_ram; depends on nothing.
`timescale 1ns / 1ps

package x86m_pkg;

    // Register file geometry.
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int REG_W     = 16;

    // Opcode groups, taken from the top five bits of an opcode byte.
    localparam logic [4:0] GRP_MOV_RM    = 5'h11;
    localparam logic [4:0] GRP_HALT      = 5'h12;
    localparam logic [4:0] GRP_MOV_IMM8  = 5'h16;
    localparam logic [4:0] GRP_MOV_IMM16 = 5'h17;

    // Register numbers that leave reset with a nonzero value.
    localparam logic [REG_IDX_W-1:0] REG_AX = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ES = 3'd4;
    localparam logic [REG_W-1:0] AX_RESET = 16'h1234;
    localparam logic [REG_W-1:0] ES_RESET = 16'd23;

    // Decoder phase codes.
    localparam logic [1:0] PHASE_OPCODE = 2'd0;
    localparam logic [1:0] PHASE_OPND1  = 2'd1;
    localparam logic [1:0] PHASE_OPND2  = 2'd2;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_DUMP    = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC,
        S_MERGE,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_HALT
    } state_t;

    // Register file access request from the sequencer.
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] waddr;
        logic [REG_W-1:0]     wdata;
        logic [REG_IDX_W-1:0] raddr;
    } rf_req_t;

    // One result beat produced by the sequencer.
    typedef struct packed {
        logic                 valid;
        kind_t                kind;
        logic [REG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     value;
        logic [7:0]           bad;
        logic                 last;
    } res_t;

    // Value a register holds after reset, before it is first written.
    function automatic logic [REG_W-1:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [REG_W-1:0] v;
        v = '0;
        if (idx == REG_AX) begin
            v = AX_RESET;
        end else if (idx == REG_ES) begin
            v = ES_RESET;
        end
        return v;
    endfunction

endpackage

// File: hdl/x86m_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module x86m_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/x86m_regfile.sv
// Register file: a RAM plus per-entry valid bits so that unwritten registers read as
// their reset value. Depends on x86m_pkg and x86m_ram.
`timescale 1ns / 1ps

module x86m_regfile (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  x86m_pkg::rf_req_t         req,
    output logic [x86m_pkg::REG_W-1:0] rdata
);

    logic [x86m_pkg::NUM_REGS-1:0]  valid_reg;
    logic [x86m_pkg::NUM_REGS-1:0]  valid_next;
    logic                           rd_valid_reg;
    logic [x86m_pkg::REG_IDX_W-1:0] rd_addr_reg;
    logic [x86m_pkg::REG_W-1:0]     ram_q;

    x86m_ram #(
        .WIDTH (x86m_pkg::REG_W),
        .DEPTH (x86m_pkg::NUM_REGS)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr),
        .rdata (ram_q)
    );

    // Mark an entry valid once it has been written.
    always_comb begin
        valid_next = valid_reg;
        if (req.we) begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Track the read address alongside the RAM read latency.
    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[req.raddr] && aresetn;
        rd_addr_reg  <= req.raddr;
    end

    assign rdata = rd_valid_reg ? ram_q : x86m_pkg::reg_reset_value(rd_addr_reg);

endmodule

// File: hdl/x86m_ctrl.sv
// Instruction decoder and sequencer: decodes code bytes, drives register file
// reads and writes and produces result beats. Depends on x86m_pkg.
`timescale 1ns / 1ps

module x86m_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 code_byte,
    input  logic                       out_free,
    input  logic [x86m_pkg::REG_W-1:0] rf_rdata,
    output x86m_pkg::rf_req_t          rf_req,
    output x86m_pkg::res_t             res
);

    x86m_pkg::state_t state_reg, state_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [7:0]                     held_op_reg, held_op_next;
    logic [7:0]                     held_low_reg, held_low_next;
    logic [x86m_pkg::REG_IDX_W-1:0] dst_reg, dst_next;
    logic                           wide_reg, wide_next;
    logic                           src_hi_reg, src_hi_next;
    logic [7:0]                     byte_val_reg, byte_val_next;
    logic [x86m_pkg::REG_IDX_W-1:0] cnt_reg, cnt_next;

    logic                           accept;
    logic [4:0]                     grp_in;
    logic [4:0]                     grp_held;
    logic                           is_seg;
    logic                           dir;
    logic                           wide;
    logic [x86m_pkg::REG_IDX_W-1:0] regf;
    logic [x86m_pkg::REG_IDX_W-1:0] rm;
    logic [x86m_pkg::REG_IDX_W-1:0] src;
    logic [x86m_pkg::REG_IDX_W-1:0] dst;
    logic [x86m_pkg::REG_W-1:0]     merged;

    assign accept   = in_valid && in_ready;
    assign grp_in   = code_byte[7:3];
    assign grp_held = held_op_reg[7:3];

    // Operand decode of a ModRM byte for the register move forms.
    always_comb begin
        is_seg = held_op_reg[2];
        dir    = held_op_reg[1];
        wide   = held_op_reg[0] || is_seg;
        regf   = is_seg ? {1'b1, code_byte[4:3]} : code_byte[5:3];
        rm     = code_byte[2:0];
        src    = dir ? rm : regf;
        dst    = dir ? regf : rm;
    end

    // Byte-lane merge of the captured byte into the destination register.
    assign merged = dst_reg[2] ? {byte_val_reg, rf_rdata[7:0]}
                               : {rf_rdata[15:8], byte_val_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= x86m_pkg::S_IDLE;
            phase_reg    <= x86m_pkg::PHASE_OPCODE;
            held_op_reg  <= '0;
            held_low_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            held_op_reg  <= held_op_next;
            held_low_reg <= held_low_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dst_reg      <= dst_next;
        wide_reg     <= wide_next;
        src_hi_reg   <= src_hi_next;
        byte_val_reg <= byte_val_next;
    end

    // Next state, register file requests and result beats.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        held_op_next  = held_op_reg;
        held_low_next = held_low_reg;
        dst_next      = dst_reg;
        wide_next     = wide_reg;
        src_hi_next   = src_hi_reg;
        byte_val_next = byte_val_reg;
        cnt_next      = cnt_reg;
        in_ready      = 1'b0;
        rf_req        = '0;
        res           = '0;

        unique case (state_reg)
            x86m_pkg::S_IDLE: begin
                // Intake waits for a free output slot so that any result fits.
                in_ready = out_free;
                if (accept) begin
                    if (phase_reg == x86m_pkg::PHASE_OPCODE) begin
                        if (grp_in == x86m_pkg::GRP_MOV_RM ||
                            grp_in == x86m_pkg::GRP_MOV_IMM8 ||
                            grp_in == x86m_pkg::GRP_MOV_IMM16) begin
                            held_op_next = code_byte;
                            phase_next   = x86m_pkg::PHASE_OPND1;
                        end else if (grp_in == x86m_pkg::GRP_HALT) begin
                            cnt_next   = '0;
                            state_next = x86m_pkg::S_DUMP_RD;
                        end else begin
                            res.valid = 1'b1;
                            res.kind  = x86m_pkg::KIND_UNKNOWN;
                            res.bad   = code_byte;
                            res.last  = 1'b1;
                        end
                    end else if (phase_reg == x86m_pkg::PHASE_OPND1 &&
                                 grp_held == x86m_pkg::GRP_MOV_RM) begin
                        // Fetch the source register first.
                        rf_req.raddr = wide ? src : {1'b0, src[1:0]};
                        src_hi_next  = src[2];
                        dst_next     = dst;
                        wide_next    = wide;
                        phase_next   = x86m_pkg::PHASE_OPCODE;
                        state_next   = x86m_pkg::S_SRC;
                    end else if (phase_reg == x86m_pkg::PHASE_OPND1 &&
                                 grp_held == x86m_pkg::GRP_MOV_IMM8) begin
                        // Fetch the destination to keep its other lane.
                        rf_req.raddr  = {1'b0, held_op_reg[1:0]};
                        dst_next      = held_op_reg[2:0];
                        byte_val_next = code_byte;
                        phase_next    = x86m_pkg::PHASE_OPCODE;
                        state_next    = x86m_pkg::S_MERGE;
                    end else if (phase_reg == x86m_pkg::PHASE_OPND1) begin
                        held_low_next = code_byte;
                        phase_next    = x86m_pkg::PHASE_OPND2;
                    end else begin
                        // High byte of a 16-bit immediate completes the write.
                        rf_req.we    = 1'b1;
                        rf_req.waddr = held_op_reg[2:0];
                        rf_req.wdata = {code_byte, held_low_reg};
                        res.valid    = 1'b1;
                        res.kind     = x86m_pkg::KIND_WRITE;
                        res.idx      = held_op_reg[2:0];
                        res.value    = {code_byte, held_low_reg};
                        res.last     = 1'b1;
                        phase_next   = x86m_pkg::PHASE_OPCODE;
                    end
                end
            end

            x86m_pkg::S_SRC: begin
                // The output slot was free at intake and nothing has used it since.
                if (wide_reg) begin
                    rf_req.we    = 1'b1;
                    rf_req.waddr = dst_reg;
                    rf_req.wdata = rf_rdata;
                    res.valid    = 1'b1;
                    res.kind     = x86m_pkg::KIND_WRITE;
                    res.idx      = dst_reg;
                    res.value    = rf_rdata;
                    res.last     = 1'b1;
                    state_next   = x86m_pkg::S_IDLE;
                end else begin
                    byte_val_next = src_hi_reg ? rf_rdata[15:8] : rf_rdata[7:0];
                    rf_req.raddr  = {1'b0, dst_reg[1:0]};
                    state_next    = x86m_pkg::S_MERGE;
                end
            end

            x86m_pkg::S_MERGE: begin
                rf_req.we    = 1'b1;
                rf_req.waddr = {1'b0, dst_reg[1:0]};
                rf_req.wdata = merged;
                res.valid    = 1'b1;
                res.kind     = x86m_pkg::KIND_WRITE;
                res.idx      = {1'b0, dst_reg[1:0]};
                res.value    = merged;
                res.last     = 1'b1;
                state_next   = x86m_pkg::S_IDLE;
            end

            x86m_pkg::S_DUMP_RD: begin
                rf_req.raddr = cnt_reg;
                state_next   = x86m_pkg::S_DUMP_OUT;
            end

            x86m_pkg::S_DUMP_OUT: begin
                // Keep the same address so a stalled beat still reads the right entry.
                rf_req.raddr = cnt_reg;
                if (out_free) begin
                    res.valid = 1'b1;
                    res.kind  = x86m_pkg::KIND_DUMP;
                    res.idx   = cnt_reg;
                    res.value = rf_rdata;
                    res.last  = (cnt_reg == x86m_pkg::REG_IDX_W'(x86m_pkg::NUM_REGS - 1));
                    cnt_next  = x86m_pkg::REG_IDX_W'(cnt_reg + 1'b1);
                    state_next = res.last ? x86m_pkg::S_HALT : x86m_pkg::S_DUMP_RD;
                end
            end

            x86m_pkg::S_HALT: begin
                // Halted: bytes are taken and dropped until reset.
                in_ready = 1'b1;
            end

            default: begin
                state_next = x86m_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/x86_mov_subset_executor.sv
// Top level of the 8086 MOV subset executor: sequencer, register file and output register.
// Depends on x86m_pkg, x86m_ctrl and x86m_regfile.
`timescale 1ns / 1ps
//
// Usage:
// Code bytes enter one per beat on the s_ channel (s_tdata = code_byte). Results leave
// on the m_ channel: m_tuser is the result kind, m_tlast marks the last result of a byte.
// A byte that only continues an instruction produces no result.
// Timing: immediate low bytes and opcode bytes other than halt keep the sequencer idle.
// An unknown opcode or a 16-bit immediate high byte shows its result in the cycle after
// it is taken. A register move passes through S_SRC (word) or S_SRC and S_MERGE (byte),
// an 8-bit immediate through S_MERGE, as the register file RAM has a single read port;
// intake resumes once the result is written to the output register.
// A halt opcode dumps the eight registers, each through S_DUMP_RD and S_DUMP_OUT, then
// every further byte is taken and dropped with no result.
// Reset: registers read ax = 0x1234, es = 23, others zero through per-entry valid bits;
// no clearing pass is needed, so the block is ready right after reset.
// Stall: a result waiting in the output register holds while m_tready is low; before halt,
// new bytes are taken only once that register is free or being emptied in the same cycle.
//
module x86_mov_subset_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] reg_index, [18:3] reg_value, [26:19] bad_opcode
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last
);

    x86m_pkg::rf_req_t          rf_req;
    x86m_pkg::res_t             res;
    logic [x86m_pkg::REG_W-1:0] rf_rdata;
    logic                       out_free;

    logic                           m_valid_reg;
    x86m_pkg::kind_t                m_kind_reg;
    logic [x86m_pkg::REG_IDX_W-1:0] m_idx_reg;
    logic [x86m_pkg::REG_W-1:0]     m_value_reg;
    logic [7:0]                     m_bad_reg;
    logic                           m_last_reg;

    assign out_free = !m_valid_reg || m_tready;

    x86m_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .code_byte (s_tdata),
        .out_free  (out_free),
        .rf_rdata  (rf_rdata),
        .rf_req    (rf_req),
        .res       (res)
    );

    x86m_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rf_req),
        .rdata   (rf_rdata)
    );

    // Output register: loads a new beat, otherwise empties when the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_kind_reg  <= res.kind;
            m_idx_reg   <= res.idx;
            m_value_reg <= res.value;
            m_bad_reg   <= res.bad;
            m_last_reg  <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_bad_reg, m_value_reg, m_idx_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: hdl/x86m_checker.sv
// Port-level checker for the MOV subset executor, bound to the top level.
// Depends on x86m_pkg.
`timescale 1ns / 1ps

module x86m_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // No result beat right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // A stalled result beat holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // An unknown opcode is a single, final beat with zeroed register fields.
    a_unknown_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == x86m_pkg::KIND_UNKNOWN |-> m_tlast && m_tdata[18:0] == '0)
        else $error("malformed unknown-opcode beat");

    // Only unknown-opcode beats carry an opcode byte.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != x86m_pkg::KIND_UNKNOWN |-> m_tdata[26:19] == 8'd0)
        else $error("opcode byte set on a register beat");

    // Register writes always end their byte's results.
    a_write_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == x86m_pkg::KIND_WRITE |-> m_tlast)
        else $error("register write beat not marked last");

endmodule

bind x86_mov_subset_executor x86m_checker u_x86m_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
